// ----- rtl/rma_pkg.sv -----
// shared types and constants for the signal-strength moving average and level block
package rma_pkg;

	localparam int RMA_WINDOW = 5;

	localparam int SAMPLE_W = 8;
	localparam int LEVEL_W  = 3;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LEVEL4 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LEVEL3 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LEVEL2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LEVEL1 = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] THR_LEVEL4_RST = -8'sd55;
	localparam logic signed [SAMPLE_W-1:0] THR_LEVEL3_RST = -8'sd65;
	localparam logic signed [SAMPLE_W-1:0] THR_LEVEL2_RST = -8'sd75;
	localparam logic signed [SAMPLE_W-1:0] THR_LEVEL1_RST = -8'sd85;

	localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

	typedef struct packed {
		logic                       sample_valid;
		logic signed [SAMPLE_W-1:0] rssi_sample;
	} rma_in_t;

	typedef struct packed {
		logic                       average_valid;
		logic signed [SAMPLE_W-1:0] average_rssi;
		logic [LEVEL_W-1:0]         strength_level;
	} rma_out_t;

	// controller to datapath
	typedef struct packed {
		logic start_valid;
		logic start_invalid;
		logic sum_step;
		logic div_load;
		logic div_step;
		logic out_load;
	} rma_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sum_last;
		logic div_last;
	} rma_sts_t;

endpackage

// ----- rtl/rma_datapath.sv -----
// sample ring, serial accumulator, bit-serial divider, threshold registers and result register
module rma_datapath import rma_pkg::*; #(
	parameter int WINDOW = RMA_WINDOW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rma_cmd_t              cmd,
	output rma_sts_t              sts,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SAMPLE_W-1:0]   cfg_data,
	output rma_out_t              result
);

	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW);
	localparam int MAG_W  = SUM_W;
	localparam int STEP_W = $clog2(MAG_W);

	logic signed [SAMPLE_W-1:0] ring_q [WINDOW];
	logic [IDX_W-1:0]           wr_idx_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic [CNT_W-1:0]           count_q;
	logic                       item_valid_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic [MAG_W-1:0]           mag_q;
	logic [CNT_W-1:0]           rem_q;
	logic                       neg_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [SAMPLE_W-1:0] thr4_q, thr3_q, thr2_q, thr1_q;
	rma_out_t                   result_q;

	logic signed [SAMPLE_W-1:0] rd_sample;
	logic [CNT_W:0]             rem_sh;
	logic [CNT_W:0]             div_diff;
	logic                       div_ge;
	logic [MAG_W-1:0]           quo_signed;
	logic signed [SAMPLE_W-1:0] avg;
	logic [LEVEL_W-1:0]         level;

	assign rd_sample = ring_q[rd_idx_q];

	assign sts.sum_last = (rd_idx_q == IDX_W'(count_q - CNT_W'(1)));
	assign sts.div_last = (step_q == STEP_W'(MAG_W - 1));

	// restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q, mag_q[MAG_W-1]};
	assign div_diff = rem_sh - {1'b0, count_q};
	assign div_ge   = (rem_sh >= {1'b0, count_q});

	// negate the magnitude quotient back for truncation toward zero
	assign quo_signed = neg_q ? (~mag_q + MAG_W'(1)) : mag_q;
	assign avg        = quo_signed[SAMPLE_W-1:0];

	always_comb begin
		if (avg >= thr4_q) begin
			level = LEVEL_4;
		end else if (avg >= thr3_q) begin
			level = LEVEL_3;
		end else if (avg >= thr2_q) begin
			level = LEVEL_2;
		end else if (avg >= thr1_q) begin
			level = LEVEL_1;
		end else begin
			level = LEVEL_0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_valid) begin
			ring_q[wr_idx_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			count_q  <= '0;
		end else if (cmd.start_invalid) begin
			wr_idx_q <= '0;
			count_q  <= '0;
		end else if (cmd.start_valid) begin
			wr_idx_q <= (wr_idx_q == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_q + IDX_W'(1);
			if (count_q != CNT_W'(WINDOW)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr4_q <= THR_LEVEL4_RST;
			thr3_q <= THR_LEVEL3_RST;
			thr2_q <= THR_LEVEL2_RST;
			thr1_q <= THR_LEVEL1_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THR_LEVEL4: thr4_q <= cfg_data;
				CFG_THR_LEVEL3: thr3_q <= cfg_data;
				CFG_THR_LEVEL2: thr2_q <= cfg_data;
				CFG_THR_LEVEL1: thr1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_valid || cmd.start_invalid) begin
			item_valid_q <= cmd.start_valid;
			acc_q        <= '0;
			rd_idx_q     <= '0;
		end
		if (cmd.sum_step) begin
			acc_q    <= acc_q + {{(SUM_W-SAMPLE_W){rd_sample[SAMPLE_W-1]}}, rd_sample};
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		if (cmd.div_load) begin
			neg_q  <= acc_q[SUM_W-1];
			mag_q  <= acc_q[SUM_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= div_ge ? div_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			mag_q  <= {mag_q[MAG_W-2:0], div_ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.out_load) begin
			if (item_valid_q) begin
				result_q.average_valid  <= 1'b1;
				result_q.average_rssi   <= avg;
				result_q.strength_level <= level;
			end else begin
				result_q.average_valid  <= 1'b0;
				result_q.average_rssi   <= '0;
				result_q.strength_level <= LEVEL_0;
			end
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/rma_ctrl.sv -----
// controller for one poll: accept, accumulate, divide, hand over the result beat
module rma_ctrl import rma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     sample_valid,
	output logic     out_valid,
	input  logic     out_ready,
	output rma_cmd_t cmd,
	input  rma_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DLOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd               = '0;
		cmd.start_valid   = accept && sample_valid;
		cmd.start_invalid = accept && !sample_valid;
		cmd.sum_step      = (state_q == ST_SUM);
		cmd.div_load      = (state_q == ST_DLOAD);
		cmd.div_step      = (state_q == ST_DIV);
		cmd.out_load      = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result beat replaces the one leaving in the same cycle
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= sample_valid ? ST_SUM : ST_FIN;
					end
				end
				ST_SUM: begin
					if (sts.sum_last) begin
						state_q <= ST_DLOAD;
					end
				end
				ST_DLOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// wait until the previous result beat has left
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/rssi_moving_average_level.sv -----
// Signal-strength moving average with a five-way level quantizer: a valid poll is
// stored in a ring of WINDOW samples, the stored samples are summed one per cycle,
// the sum is divided by their count one quotient bit per cycle (truncating toward
// zero) and the mean is compared against four programmable thresholds. A valid
// poll passes through the states ST_SUM, ST_DLOAD, ST_DIV and ST_FIN; the sum runs over
// count stored samples (1 to WINDOW) and the divide over MAG_W = 9 + clog2(WINDOW)
// quotient bits. An invalid poll goes straight to ST_FIN, empties the ring and
// returns level 0 with the average marked invalid. A result waiting at the output
// does not hold off the next poll until it is itself done.
// Threshold writes are taken in any cycle and should only be made while idle.
module rssi_moving_average_level import rma_pkg::*; #(
	parameter int WINDOW = RMA_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rma_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rma_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data
);

	rma_cmd_t cmd;
	rma_sts_t sts;

	assign cfg_ready = 1'b1;

	rma_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_valid (in_data.sample_valid),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	rma_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (in_data.rssi_sample),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (out_data)
	);

endmodule

// ----- tb/tb_top.sv -----
// testbench for the signal-strength moving average and level block
module tb_top;
	import rma_pkg::*;

	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	rma_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	rma_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_THR_LEVEL4;
	logic [SAMPLE_W-1:0]  cfg_data = '0;

	rma_in_t  poll_q[$];
	rma_out_t level_q[$];
	rma_out_t level_want;

	// threshold copy, indexed by register index
	logic signed [SAMPLE_W-1:0] level_thr[4];
	int ring_smp[RMA_WINDOW];
	int wr_slot;
	int fill;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int pushed = 0;
	int accepted = 0;
	int checked = 0;
	int errors = 0;
	int invalid_polls = 0;
	int settings = 0;

	rssi_moving_average_level u_dut (.*);

	always #5 clk = ~clk;

	function automatic rma_out_t poll_average(input rma_in_t p);
		rma_out_t r;
		int sum;
		int avg;
		r = '0;
		if (!p.sample_valid) begin
			wr_slot = 0;
			fill = 0;
			invalid_polls++;
			return r;
		end
		ring_smp[wr_slot] = int'($signed(p.rssi_sample));
		wr_slot = (wr_slot + 1) % RMA_WINDOW;
		if (fill < RMA_WINDOW)
			fill++;
		sum = 0;
		for (int i = 0; i < fill; i++)
			sum += ring_smp[i];
		avg = sum / fill;
		r.average_valid = 1'b1;
		r.average_rssi = avg[SAMPLE_W-1:0];
		// first threshold met wins, even when they are out of order
		if (avg >= level_thr[CFG_THR_LEVEL4])
			r.strength_level = LEVEL_4;
		else if (avg >= level_thr[CFG_THR_LEVEL3])
			r.strength_level = LEVEL_3;
		else if (avg >= level_thr[CFG_THR_LEVEL2])
			r.strength_level = LEVEL_2;
		else if (avg >= level_thr[CFG_THR_LEVEL1])
			r.strength_level = LEVEL_1;
		else
			r.strength_level = LEVEL_0;
		return r;
	endfunction

	task automatic report(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic push_poll(input logic v, input logic [SAMPLE_W-1:0] s);
		rma_in_t p;
		p.sample_valid = v;
		p.rssi_sample = s;
		poll_q.push_back(p);
		pushed++;
	endtask

	// mostly plausible readings, some full-range bytes and extremes, few dropouts
	task automatic push_random_polls(input int n);
		int r;
		logic [SAMPLE_W-1:0] extremes[3];
		extremes = '{8'h80, 8'h00, 8'h7f};
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 7)
				push_poll(1'b0, 8'($urandom));
			else if (r < 78)
				push_poll(1'b1, 8'(-$urandom_range(100, 30)));
			else if (r < 92)
				push_poll(1'b1, 8'($urandom));
			else
				push_poll(1'b1, extremes[$urandom_range(2)]);
		end
	endtask

	task automatic set_thresholds(input logic signed [SAMPLE_W-1:0] t4, t3, t2, t1);
		logic [CFG_IDX_W-1:0] idx[4];
		logic signed [SAMPLE_W-1:0] val[4];
		idx = '{CFG_THR_LEVEL4, CFG_THR_LEVEL3, CFG_THR_LEVEL2, CFG_THR_LEVEL1};
		val = '{t4, t3, t2, t1};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			level_thr[idx[i]] = val[i];
		end
		settings++;
	endtask

	task automatic wait_results_done;
		while (checked < pushed)
			@(posedge clk);
	endtask

	// poll driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				level_q.push_back(poll_average(in_data));
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (poll_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_data  <= poll_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				checked++;
				if (level_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					level_want = level_q.pop_front();
					if (out_data.average_valid !== level_want.average_valid)
						report($sformatf("average_valid got %0b want %0b",
							out_data.average_valid, level_want.average_valid));
					if (out_data.average_rssi !== level_want.average_rssi)
						report($sformatf("average_rssi got %0d want %0d",
							out_data.average_rssi, level_want.average_rssi));
					if (out_data.strength_level !== level_want.strength_level)
						report($sformatf("strength_level got %0d want %0d",
							out_data.strength_level, level_want.strength_level));
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] probes[4];
		logic signed [SAMPLE_W-1:0] t4, t3, t2, t1;
		probes = '{-8'sd55, -8'sd56, -8'sd85, -8'sd86};
		level_thr = '{THR_LEVEL4_RST, THR_LEVEL3_RST, THR_LEVEL2_RST, THR_LEVEL1_RST};
		wr_slot = 0;
		fill = 0;
		tx_idle_pct = 11;
		rx_idle_pct = 72;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// dropout on an empty ring, fill and wrap at both extremes, truncation of small means
		push_poll(1'b0, 8'h55);
		repeat (6) push_poll(1'b1, 8'h80);
		repeat (5) push_poll(1'b1, 8'h7f);
		push_poll(1'b0, 8'h7f);
		push_poll(1'b1, 8'h00);
		push_poll(1'b1, 8'hff);
		push_poll(1'b1, 8'hfe);
		// single samples right at and just under the default thresholds
		foreach (probes[i]) begin
			push_poll(1'b0, 8'hff);
			push_poll(1'b1, probes[i]);
		end
		push_random_polls(130);
		wait_results_done();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph >= 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (ph >= 2) begin
				tx_idle_pct = 72;
				rx_idle_pct = 11;
			end
			case (ph)
				0: set_thresholds(8'sh80, 8'sh80, 8'sh80, 8'sh80);
				1: set_thresholds(8'sh7f, 8'sh7f, 8'sh7f, 8'sh7f);
				2: set_thresholds(8'sh00, 8'sh00, 8'sh00, 8'sh00);
				3: set_thresholds(-8'sd100, -8'sd50, 8'sh80, 8'sh00);
				4: begin
					t4 = 8'(-$urandom_range(40, 20));
					t3 = t4 - 8'($urandom_range(20));
					t2 = t3 - 8'($urandom_range(20));
					t1 = t2 - 8'($urandom_range(20));
					set_thresholds(t4, t3, t2, t1);
				end
				default: set_thresholds(THR_LEVEL4_RST, THR_LEVEL3_RST,
					THR_LEVEL2_RST, THR_LEVEL1_RST);
			endcase
			push_random_polls(150);
			// long output stall while polls keep coming, so the input backs up
			if (ph == 1)
				hold_token++;
			wait_results_done();
		end

		repeat (30) @(posedge clk);
		if (level_q.size() != 0)
			report($sformatf("%0d expected results never arrived", level_q.size()));
		$display("checked %0d results from %0d polls (%0d dropouts) over %0d threshold settings",
			checked, accepted, invalid_polls, settings + 1);
		$display("with sender/receiver gaps in both mixes and a %0d-cycle output stall",
			HOLD_CYCLES);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
